// ----- rtl/humidity_sensor_frame_decoder_macros.svh -----
// Assertion macros shared by the frame decoder RTL.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define HSFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define HSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hsfd_pkg.sv -----
// Types and constants shared by the humidity sensor frame decoder.
package hsfd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [15:0] FULL_SCALE  = 16'd65535;

  typedef enum logic [2:0] {
    POS_TEMP_HI  = 3'd0,
    POS_TEMP_LO  = 3'd1,
    POS_TEMP_CRC = 3'd2,
    POS_HUM_HI   = 3'd3,
    POS_HUM_LO   = 3'd4,
    POS_HUM_CRC  = 3'd5
  } pos_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic        [13:0] humidity_centi;
    logic        [15:0] raw_temperature;
    logic        [15:0] raw_humidity;
    status_t            status;
  } out_item_t;

endpackage

// ----- rtl/hsfd_crc8.sv -----
// Byte-wide CRC-8 update, polynomial 0x31, MSB first.
module hsfd_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);
  import hsfd_pkg::*;

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- rtl/hsfd_scale.sv -----
// Scales the raw sensor words to hundredths of a degree and of a percent.
module hsfd_scale (
  input  logic        [15:0] raw_temp,
  input  logic        [15:0] raw_hum,
  output logic signed [14:0] temp_centi,
  output logic        [13:0] hum_centi
);
  import hsfd_pkg::*;

  // floor(x / 65535) with x = q * 65536 + r equals q plus one when q + r
  // reaches 65535; q + r stays below twice 65535 for these products.
  logic [30:0] t_prod;
  logic [14:0] t_q;
  logic [16:0] t_sum;
  logic [14:0] t_floor;
  logic [15:0] t_signed;
  logic [29:0] h_prod;
  logic [13:0] h_q;
  logic [16:0] h_sum;

  always_comb begin
    t_prod   = 31'(raw_temp) * 31'(TEMP_SCALE);
    t_q      = t_prod[30:16];
    t_sum    = 17'(t_q) + 17'(t_prod[15:0]);
    t_floor  = t_q + 15'(t_sum >= 17'(FULL_SCALE));
    t_signed = 16'(t_floor) - TEMP_OFFSET;
    temp_centi = signed'(t_signed[14:0]);

    h_prod    = 30'(raw_hum) * 30'(HUM_SCALE);
    h_q       = h_prod[29:16];
    h_sum     = 17'(h_q) + 17'(h_prod[15:0]);
    hum_centi = h_q + 14'(h_sum >= 17'(FULL_SCALE));
  end

endmodule

// ----- rtl/humidity_sensor_frame_decoder.sv -----
// Top level of the humidity sensor frame decoder: input stage, frame tracking, result register.
// Output: the result register captures a frame's reading when its sixth byte leaves the input
// register, and it holds out_valid high until the result transfers out.
// Throughput: one byte per cycle; the input register, frame logic and result register form a
// two-stage pipeline, and only a held result can stall a sixth byte in the input register.
// Reset: rst_n is synchronous and active low; it empties both stages, sets the byte position to
// the first byte of a frame and loads the running CRC with its initial value 0xFF.
`include "humidity_sensor_frame_decoder_macros.svh"

module humidity_sensor_frame_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsfd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsfd_pkg::out_item_t  out_data
);
  import hsfd_pkg::*;

  // Input stage: one received byte waits here for the frame logic.
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;

  // Frame state, updated once for every byte that leaves the input stage.
  pos_t        pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic        temp_bad_r, temp_bad_nxt;
  logic [7:0]  hum_hi_r, hum_hi_nxt;
  logic [7:0]  hum_lo_r, hum_lo_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic        in_xfer;
  logic        s1_go;
  logic        s1_fire;
  logic        emit;
  logic [7:0]  crc_base;
  logic [7:0]  crc_fed;
  logic signed [14:0] temp_centi;
  logic        [13:0] hum_centi;
  status_t     status_val;

  // A frame-start flag, or a position code outside the frame, makes this byte the first one.
  always_comb begin
    if (s1_data_r.frame_start || !(pos_r inside {[POS_TEMP_HI:POS_HUM_CRC]})) begin
      pos_eff = POS_TEMP_HI;
    end else begin
      pos_eff = pos_r;
    end
  end

  // Only the final byte of a frame needs room in the result register.
  assign s1_go    = (pos_eff != POS_HUM_CRC) || !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_go;
  assign emit     = s1_fire && (pos_eff == POS_HUM_CRC);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_valid && in_ready;

  // The CRC restarts from its initial value on the high byte of each word.
  assign crc_base = ((pos_eff == POS_TEMP_HI) || (pos_eff == POS_HUM_HI)) ? CRC_INIT : crc_r;

  hsfd_crc8 u_crc8 (
    .crc_in  (crc_base),
    .data_in (s1_data_r.data_byte),
    .crc_out (crc_fed)
  );

  hsfd_scale u_scale (
    .raw_temp   (temp_word_r),
    .raw_hum    ({hum_hi_r, hum_lo_r}),
    .temp_centi (temp_centi),
    .hum_centi  (hum_centi)
  );

  // A bad temperature CRC is reported ahead of a bad humidity CRC.
  always_comb begin
    if (temp_bad_r) begin
      status_val = STATUS_TEMP_CRC;
    end else if (crc_r != s1_data_r.data_byte) begin
      status_val = STATUS_HUM_CRC;
    end else begin
      status_val = STATUS_OK;
    end
  end

  // Next byte position.
  always_comb begin
    pos_nxt = pos_r;
    if (s1_fire) begin
      case (pos_eff)
        POS_TEMP_HI:  pos_nxt = POS_TEMP_LO;
        POS_TEMP_LO:  pos_nxt = POS_TEMP_CRC;
        POS_TEMP_CRC: pos_nxt = POS_HUM_HI;
        POS_HUM_HI:   pos_nxt = POS_HUM_LO;
        POS_HUM_LO:   pos_nxt = POS_HUM_CRC;
        POS_HUM_CRC:  pos_nxt = POS_TEMP_HI;
        default:      pos_nxt = POS_TEMP_LO;
      endcase
    end
  end

  // Data updates for each byte position.
  always_comb begin
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    temp_bad_nxt  = temp_bad_r;
    hum_hi_nxt    = hum_hi_r;
    hum_lo_nxt    = hum_lo_r;
    if (s1_fire) begin
      case (pos_eff)
        POS_TEMP_HI: begin
          crc_nxt       = crc_fed;
          temp_word_nxt = {s1_data_r.data_byte, 8'h00};
        end
        POS_TEMP_LO: begin
          crc_nxt       = crc_fed;
          temp_word_nxt = {temp_word_r[15:8], s1_data_r.data_byte};
        end
        POS_TEMP_CRC: begin
          temp_bad_nxt = (crc_r != s1_data_r.data_byte);
          crc_nxt      = CRC_INIT;
        end
        POS_HUM_HI: begin
          crc_nxt    = crc_fed;
          hum_hi_nxt = s1_data_r.data_byte;
        end
        POS_HUM_LO: begin
          crc_nxt    = crc_fed;
          hum_lo_nxt = s1_data_r.data_byte;
        end
        POS_HUM_CRC: begin
          crc_nxt = CRC_INIT;
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
    end
  end

  // The result register refills on the final byte and empties on an output transfer.
  always_comb begin
    out_data_nxt = out_data_r;
    if (emit) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.temperature_centi = temp_centi;
      out_data_nxt.humidity_centi    = hum_centi;
      out_data_nxt.raw_temperature   = temp_word_r;
      out_data_nxt.raw_humidity      = {hum_hi_r, hum_lo_r};
      out_data_nxt.status            = status_val;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= POS_TEMP_HI;
      crc_r       <= CRC_INIT;
      temp_bad_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_bad_r  <= temp_bad_nxt;
    end
  end

  // Payload registers carry no reset; each is written before it is read.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    temp_word_r <= temp_word_nxt;
    hum_hi_r    <= hum_hi_nxt;
    hum_lo_r    <= hum_lo_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A final byte that meets a held result must keep the input closed.
  `HSFD_ASSERT_SAME(a_final_byte_stall, s1_valid_r && (pos_eff == POS_HUM_CRC) && out_valid_r && !out_ready, !in_ready, "final byte not stalled behind held result")
  // Every completed frame shows up as a valid result in the next cycle.
  `HSFD_ASSERT_NEXT(a_emit_shows_result, emit, out_valid, "completed frame produced no result")
  // The humidity word always starts from a freshly seeded CRC.
  `HSFD_ASSERT_SAME(a_crc_seeded, pos_r == POS_HUM_HI, crc_r == CRC_INIT, "CRC not reseeded before humidity word")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the humidity sensor frame decoder: directed frames, then random traffic.
module testbench;
  import hsfd_pkg::*;

  // Scaling constants of the sensor transfer function, kept apart from the RTL's own copies.
  localparam int unsigned TEMP_SPAN_CENTI = 17500;
  localparam int unsigned TEMP_BASE_CENTI = 4500;
  localparam int unsigned HUM_SPAN_CENTI  = 10000;
  localparam int unsigned RAW_FULL        = 65535;

  // Random traffic size, the long receiver hold-off, and the window in which the sender runs flat out.
  localparam int RANDOM_BYTES   = 1125;
  localparam int HOLD_CYCLES    = 300;
  localparam int EAGER_FIRST    = 500;
  localparam int EAGER_LAST     = 700;
  localparam int DRAIN_CYCLES   = 8;

  // Receiver stall modes; a new mode is drawn whenever the low seven bits of rx_cycle are zero.
  typedef enum logic [1:0] {
    RX_ALWAYS  = 2'd0,
    RX_HALF    = 2'd1,
    RX_SPARSE  = 2'd2,
    RX_PATTERN = 2'd3
  } rx_mode_t;
  localparam logic [7:0] RX_PATTERN_BITS = 8'b1011_0010;

  // One row of the directed table: a byte to send and, on a sixth byte, an optional
  // hand-written reading that replaces the predicted one.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t reading;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  humidity_sensor_frame_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off here if the block hangs; the slowest correct run is far shorter.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // Frame predictor. It mirrors the decoder's byte position, running CRC and captured bytes, and
  // hands back a reading whenever a byte completes a frame.
  // ---------------------------------------------------------------------------------------------
  pos_t       frame_pos  = POS_TEMP_HI;
  logic [7:0] frame_crc  = CRC_INIT;
  logic [15:0] temp_word = '0;
  logic       temp_bad   = 1'b0;
  logic [7:0] hum_hi     = '0;
  logic [7:0] hum_lo     = '0;

  out_item_t pending_readings[$];
  stim_row_t dir_table[$];

  int n_sent      = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int n_dropped   = 0;
  int n_temp_bad  = 0;
  int n_hum_bad   = 0;
  int burst_left  = 0;
  bit sender_eager = 1'b0;

  // Receiver state.
  rx_mode_t rx_mode      = RX_ALWAYS;
  logic [7:0] rx_cycle   = '0;
  int       hold_left    = 0;
  logic     hold_request = 1'b0;
  logic     hold_done    = 1'b0;

  // CRC-8, polynomial 0x31, MSB first, one byte at a time.
  function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    int k;
    c = crc ^ b;
    for (k = 0; k < 8; k++)
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [7:0] word_crc(logic [15:0] w);
    return crc8_feed(crc8_feed(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  function automatic out_item_t make_reading(int tc, int hc, int rt, int rh, status_t st);
    out_item_t r;
    r.temperature_centi = tc[14:0];
    r.humidity_centi    = hc[13:0];
    r.raw_temperature   = rt[15:0];
    r.raw_humidity      = rh[15:0];
    r.status            = st;
    return r;
  endfunction

  task automatic decode_frame_byte(input in_item_t it, output bit produced,
                                   output out_item_t r);
    pos_t p;
    logic [7:0] b;
    logic [31:0] rt, rh, tq, hq;
    b = it.data_byte;
    produced = 1'b0;
    r = '0;
    // A start flag in the middle of a frame throws the partial frame away.
    if (it.frame_start && frame_pos != POS_TEMP_HI)
      n_dropped++;
    p = it.frame_start ? POS_TEMP_HI : frame_pos;
    case (p)
      POS_TEMP_HI: begin
        frame_crc = crc8_feed(CRC_INIT, b);
        temp_word = {b, 8'h00};
        frame_pos = POS_TEMP_LO;
      end
      POS_TEMP_LO: begin
        frame_crc = crc8_feed(frame_crc, b);
        temp_word[7:0] = b;
        frame_pos = POS_TEMP_CRC;
      end
      POS_TEMP_CRC: begin
        temp_bad  = (frame_crc != b);
        frame_crc = CRC_INIT;
        frame_pos = POS_HUM_HI;
      end
      POS_HUM_HI: begin
        frame_crc = crc8_feed(CRC_INIT, b);
        hum_hi    = b;
        frame_pos = POS_HUM_LO;
      end
      POS_HUM_LO: begin
        frame_crc = crc8_feed(frame_crc, b);
        hum_lo    = b;
        frame_pos = POS_HUM_CRC;
      end
      default: begin
        rt = {16'h0, temp_word};
        rh = {16'h0, hum_hi, hum_lo};
        tq = (TEMP_SPAN_CENTI * rt) / RAW_FULL;
        hq = (HUM_SPAN_CENTI * rh) / RAW_FULL;
        r.temperature_centi = tq[14:0] - TEMP_BASE_CENTI[14:0];
        r.humidity_centi    = hq[13:0];
        r.raw_temperature   = rt[15:0];
        r.raw_humidity      = rh[15:0];
        // The temperature check wins when both CRCs are wrong.
        if (temp_bad)
          r.status = STATUS_TEMP_CRC;
        else if (frame_crc != b)
          r.status = STATUS_HUM_CRC;
        else
          r.status = STATUS_OK;
        produced  = 1'b1;
        frame_crc = CRC_INIT;
        frame_pos = POS_TEMP_HI;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------------------------
  // Sender. Each byte is offered until its transfer, then fed to the predictor. Bytes go out in
  // bursts of random length separated by random gaps; while the sender is eager there are no gaps.
  // ---------------------------------------------------------------------------------------------
  task send_byte(input in_item_t it, input bit typed, input out_item_t typed_reading);
    bit produced;
    out_item_t predicted;
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    decode_frame_byte(it, produced, predicted);
    if (produced)
      pending_readings.push_back(typed ? typed_reading : predicted);
    n_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_eager ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task add_frame(input logic [47:0] bytes, input logic start, input bit typed,
                 input out_item_t reading);
    stim_row_t row;
    int i;
    for (i = 0; i < 6; i++) begin
      row.item.data_byte   = bytes[47 - 8*i -: 8];
      row.item.frame_start = (i == 0) ? start : 1'b0;
      row.typed            = typed && (i == 5);
      row.reading          = reading;
      dir_table.push_back(row);
    end
  endtask

  task add_byte(input logic [7:0] b, input logic start);
    stim_row_t row;
    row.item.data_byte   = b;
    row.item.frame_start = start;
    row.typed            = 1'b0;
    row.reading          = '0;
    dir_table.push_back(row);
  endtask

  // Zero or all ones now and then, otherwise a random word.
  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0)
      return 16'h0000;
    if (r == 1)
      return 16'hFFFF;
    return 16'($urandom());
  endfunction

  // One random transaction: a clean frame, a frame with a corrupted CRC, a frame cut short,
  // or a few bytes of line noise.
  task send_random_unit();
    logic [15:0] t, h;
    logic [7:0]  fb[6];
    logic        start;
    in_item_t    it;
    int kind, which, cut, i;
    kind = $urandom_range(0, 19);
    if (kind >= 18) begin
      cut = $urandom_range(1, 4);
      for (i = 0; i < cut; i++) begin
        it.data_byte   = 8'($urandom());
        it.frame_start = ($urandom_range(0, 7) == 0);
        send_byte(it, 1'b0, '0);
      end
    end else begin
      t = pick_word();
      h = pick_word();
      fb[0] = t[15:8];
      fb[1] = t[7:0];
      fb[2] = word_crc(t);
      fb[3] = h[15:8];
      fb[4] = h[7:0];
      fb[5] = word_crc(h);
      if (kind >= 13 && kind <= 15) begin
        which = $urandom_range(0, 2);
        if (which != 1)
          fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
        if (which != 0)
          fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
      end
      cut = (kind >= 16) ? $urandom_range(1, 5) : 6;
      // Resynchronize whenever the decoder is not at a frame boundary.
      start = (frame_pos != POS_TEMP_HI) ? 1'b1 : 1'($urandom_range(0, 1));
      for (i = 0; i < cut; i++) begin
        it.data_byte   = fb[i];
        it.frame_start = (i == 0) ? start : 1'b0;
        send_byte(it, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Receiver. Ready follows a stall mode that is drawn anew whenever the low seven bits of rx_cycle
  // are zero. Once the stimulus asks, it holds ready low for a long stretch so that both pipeline
  // stages fill and in_ready drops.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle[6:0] == 7'd0)
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= RX_PATTERN_BITS[rx_cycle[2:0]];
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Checker. Every result transfer is matched against the oldest pending reading, field by field.
  // ---------------------------------------------------------------------------------------------
  task report_mismatch(input string field, input longint want, input longint got);
    n_errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  task compare_reading(input out_item_t want, input out_item_t got);
    if (got.temperature_centi !== want.temperature_centi)
      report_mismatch("temperature_centi", want.temperature_centi, got.temperature_centi);
    if (got.humidity_centi !== want.humidity_centi)
      report_mismatch("humidity_centi", want.humidity_centi, got.humidity_centi);
    if (got.raw_temperature !== want.raw_temperature)
      report_mismatch("raw_temperature", want.raw_temperature, got.raw_temperature);
    if (got.raw_humidity !== want.raw_humidity)
      report_mismatch("raw_humidity", want.raw_humidity, got.raw_humidity);
    if (got.status !== want.status)
      report_mismatch("status", want.status, got.status);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, got raw %h/%h", $time,
                 out_data.raw_temperature, out_data.raw_humidity);
      end else begin
        want = pending_readings.pop_front();
        compare_reading(want, out_data);
        n_checked++;
        if (want.status == STATUS_TEMP_CRC)
          n_temp_bad++;
        if (want.status == STATUS_HUM_CRC)
          n_hum_bad++;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus: reset, the directed table, random traffic, then drain and report.
  // ---------------------------------------------------------------------------------------------
  initial begin
    int i;
    int random_start;

    // All-zero frame with good CRCs: the bottom of both scales.
    add_frame({8'h00, 8'h00, word_crc(16'h0000), 8'h00, 8'h00, word_crc(16'h0000)}, 1'b1,
              1'b1, make_reading(-4500, 0, 16'h0000, 16'h0000, STATUS_OK));
    // Both CRCs wrong: the temperature failure is the one reported, and the readings still
    // come from the bytes as received.
    add_frame({8'hFF, 8'hFF, ~word_crc(16'hFFFF), 8'h00, 8'h00, ~word_crc(16'h0000)}, 1'b1,
              1'b1, make_reading(13000, 0, 16'hFFFF, 16'h0000, STATUS_TEMP_CRC));
    // A frame cut short after two bytes; the next start flag drops it without a result.
    add_byte(8'hBE, 1'b1);
    add_byte(8'hEF, 1'b0);
    // Full-scale words with only the humidity CRC wrong.
    add_frame({8'hFF, 8'hFF, word_crc(16'hFFFF), 8'hFF, 8'hFF, ~word_crc(16'hFFFF)}, 1'b1,
              1'b1, make_reading(13000, 10000, 16'hFFFF, 16'hFFFF, STATUS_HUM_CRC));
    // The textbook CRC example, 0xBEEF gives 0x92, sent without a start flag at a boundary.
    add_frame({8'hBE, 8'hEF, 8'h92, 8'hBE, 8'hEF, 8'h92}, 1'b0, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_table.size(); i++)
      send_byte(dir_table[i].item, dir_table[i].typed, dir_table[i].reading);

    // Random traffic. Partway through, the receiver is asked for its long hold-off while the
    // sender runs without gaps, so the decoder backs up into its input.
    random_start = n_sent;
    while (n_sent - random_start < RANDOM_BYTES) begin
      sender_eager = (n_sent >= EAGER_FIRST && n_sent < EAGER_LAST);
      if (n_sent >= EAGER_FIRST && !hold_request)
        hold_request <= 1'b1;
      send_random_unit();
    end
    in_valid <= 1'b0;

    while (pending_readings.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; checked %0d frames, %0d with a bad temperature CRC, %0d with a bad",
             n_sent, n_checked, n_temp_bad, n_hum_bad);
    $display("humidity CRC; %0d partial frames were dropped by a resync.", n_dropped);
    if (n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- humidity_sensor_frame_decoder.f -----
+incdir+rtl
rtl/hsfd_pkg.sv
rtl/hsfd_crc8.sv
rtl/hsfd_scale.sv
rtl/humidity_sensor_frame_decoder.sv
tb/sv/testbench.sv
